// File: src/m6502_pkg.sv
package m6502_pkg;

    // Memory geometry
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // Configuration register indexes
    localparam logic [1:0] CFG_JMP_BUG = 2'd0;
    localparam logic [1:0] CFG_START   = 2'd1;
    localparam logic [1:0] CFG_STACK   = 2'd2;

    // Reset values
    localparam logic [15:0] RST_PC     = 16'h0600;
    localparam logic [7:0]  RST_SP     = 8'hFF;
    localparam logic [7:0]  RST_STATUS = 8'h20;

    // Status bits
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_U = 5;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0] STACK_PAGE = 8'h01;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_SETPC = 2'd2,
        ACT_EXEC  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        AM_IMP, AM_ACC, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABX, AM_ABY,
        AM_IND, AM_IZX, AM_IZY, AM_REL
    } t_mode;

    typedef enum logic [5:0] {
        OP_BAD, OP_ADC, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI,
        OP_BNE, OP_BPL, OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_CMP,
        OP_CPX, OP_CPY, OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX, OP_INY, OP_JMP,
        OP_JSR, OP_LDA, OP_LDX, OP_LDY, OP_LSR, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA,
        OP_PLP, OP_ROL, OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_STA,
        OP_STX, OP_STY, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RDCAP, S_DEC, S_B1, S_B2, S_I1, S_I2, S_P1, S_P2,
        S_EA, S_LOAD, S_EXEC, S_POP1, S_POP2, S_POP3, S_BRK2, S_BRK3, S_JSR2, S_DONE
    } t_state;

    // Micro-operations issued by the controller to the datapath
    typedef enum logic [4:0] {
        U_NONE, U_CLR, U_WRITE, U_READ, U_SETPC, U_FETCH, U_CAPT, U_DEC, U_B1, U_B2,
        U_I1, U_I2, U_P1, U_P2, U_EA, U_LOAD, U_EXEC, U_POP1, U_POP2, U_POP3,
        U_BRK2, U_BRK3, U_JSR2, U_OUT
    } t_uop;

    typedef struct packed {
        t_op   op;
        t_mode mode;
    } t_dec;

    typedef struct packed {
        t_uop  uop;
        t_op   op;
        t_mode mode;
    } t_cmd;

    typedef struct packed {
        t_op   dec_op;
        t_mode dec_mode;
        logic  clr_last;
        logic  out_free;
    } t_sts;

    function automatic t_dec decode(input logic [7:0] opc);
        t_dec d;
        d = '{OP_BAD, AM_IMP};
        case (opc)
            8'h00: d = '{OP_BRK, AM_IMP};  8'h01: d = '{OP_ORA, AM_IZX};
            8'h05: d = '{OP_ORA, AM_ZP};   8'h06: d = '{OP_ASL, AM_ZP};
            8'h08: d = '{OP_PHP, AM_IMP};  8'h09: d = '{OP_ORA, AM_IMM};
            8'h0A: d = '{OP_ASL, AM_ACC};  8'h0D: d = '{OP_ORA, AM_ABS};
            8'h0E: d = '{OP_ASL, AM_ABS};
            8'h10: d = '{OP_BPL, AM_REL};  8'h11: d = '{OP_ORA, AM_IZY};
            8'h15: d = '{OP_ORA, AM_ZPX};  8'h16: d = '{OP_ASL, AM_ZPX};
            8'h18: d = '{OP_CLC, AM_IMP};  8'h19: d = '{OP_ORA, AM_ABY};
            8'h1D: d = '{OP_ORA, AM_ABX};  8'h1E: d = '{OP_ASL, AM_ABX};
            8'h20: d = '{OP_JSR, AM_ABS};  8'h21: d = '{OP_AND, AM_IZX};
            8'h24: d = '{OP_BIT, AM_ZP};   8'h25: d = '{OP_AND, AM_ZP};
            8'h26: d = '{OP_ROL, AM_ZP};   8'h28: d = '{OP_PLP, AM_IMP};
            8'h29: d = '{OP_AND, AM_IMM};  8'h2A: d = '{OP_ROL, AM_ACC};
            8'h2C: d = '{OP_BIT, AM_ABS};  8'h2D: d = '{OP_AND, AM_ABS};
            8'h2E: d = '{OP_ROL, AM_ABS};
            8'h30: d = '{OP_BMI, AM_REL};  8'h31: d = '{OP_AND, AM_IZY};
            8'h35: d = '{OP_AND, AM_ZPX};  8'h36: d = '{OP_ROL, AM_ZPX};
            8'h38: d = '{OP_SEC, AM_IMP};  8'h39: d = '{OP_AND, AM_ABY};
            8'h3D: d = '{OP_AND, AM_ABX};  8'h3E: d = '{OP_ROL, AM_ABX};
            8'h40: d = '{OP_RTI, AM_IMP};  8'h41: d = '{OP_EOR, AM_IZX};
            8'h45: d = '{OP_EOR, AM_ZP};   8'h46: d = '{OP_LSR, AM_ZP};
            8'h48: d = '{OP_PHA, AM_IMP};  8'h49: d = '{OP_EOR, AM_IMM};
            8'h4A: d = '{OP_LSR, AM_ACC};  8'h4C: d = '{OP_JMP, AM_ABS};
            8'h4D: d = '{OP_EOR, AM_ABS};  8'h4E: d = '{OP_LSR, AM_ABS};
            8'h50: d = '{OP_BVC, AM_REL};  8'h51: d = '{OP_EOR, AM_IZY};
            8'h55: d = '{OP_EOR, AM_ZPX};  8'h56: d = '{OP_LSR, AM_ZPX};
            8'h58: d = '{OP_CLI, AM_IMP};  8'h59: d = '{OP_EOR, AM_ABY};
            8'h5D: d = '{OP_EOR, AM_ABX};  8'h5E: d = '{OP_LSR, AM_ABX};
            8'h60: d = '{OP_RTS, AM_IMP};  8'h61: d = '{OP_ADC, AM_IZX};
            8'h65: d = '{OP_ADC, AM_ZP};   8'h66: d = '{OP_ROR, AM_ZP};
            8'h68: d = '{OP_PLA, AM_IMP};  8'h69: d = '{OP_ADC, AM_IMM};
            8'h6A: d = '{OP_ROR, AM_ACC};  8'h6C: d = '{OP_JMP, AM_IND};
            8'h6D: d = '{OP_ADC, AM_ABS};  8'h6E: d = '{OP_ROR, AM_ABS};
            8'h70: d = '{OP_BVS, AM_REL};  8'h71: d = '{OP_ADC, AM_IZY};
            8'h75: d = '{OP_ADC, AM_ZPX};  8'h76: d = '{OP_ROR, AM_ZPX};
            8'h78: d = '{OP_SEI, AM_IMP};  8'h79: d = '{OP_ADC, AM_ABY};
            8'h7D: d = '{OP_ADC, AM_ABX};  8'h7E: d = '{OP_ROR, AM_ABX};
            8'h81: d = '{OP_STA, AM_IZX};  8'h84: d = '{OP_STY, AM_ZP};
            8'h85: d = '{OP_STA, AM_ZP};   8'h86: d = '{OP_STX, AM_ZP};
            8'h88: d = '{OP_DEY, AM_IMP};  8'h8A: d = '{OP_TXA, AM_IMP};
            8'h8C: d = '{OP_STY, AM_ABS};  8'h8D: d = '{OP_STA, AM_ABS};
            8'h8E: d = '{OP_STX, AM_ABS};
            8'h90: d = '{OP_BCC, AM_REL};  8'h91: d = '{OP_STA, AM_IZY};
            8'h94: d = '{OP_STY, AM_ZPX};  8'h95: d = '{OP_STA, AM_ZPX};
            8'h96: d = '{OP_STX, AM_ZPY};  8'h98: d = '{OP_TYA, AM_IMP};
            8'h99: d = '{OP_STA, AM_ABY};  8'h9A: d = '{OP_TXS, AM_IMP};
            8'h9D: d = '{OP_STA, AM_ABX};
            8'hA0: d = '{OP_LDY, AM_IMM};  8'hA1: d = '{OP_LDA, AM_IZX};
            8'hA2: d = '{OP_LDX, AM_IMM};  8'hA4: d = '{OP_LDY, AM_ZP};
            8'hA5: d = '{OP_LDA, AM_ZP};   8'hA6: d = '{OP_LDX, AM_ZP};
            8'hA8: d = '{OP_TAY, AM_IMP};  8'hA9: d = '{OP_LDA, AM_IMM};
            8'hAA: d = '{OP_TAX, AM_IMP};  8'hAC: d = '{OP_LDY, AM_ABS};
            8'hAD: d = '{OP_LDA, AM_ABS};  8'hAE: d = '{OP_LDX, AM_ABS};
            8'hB0: d = '{OP_BCS, AM_REL};  8'hB1: d = '{OP_LDA, AM_IZY};
            8'hB4: d = '{OP_LDY, AM_ZPX};  8'hB5: d = '{OP_LDA, AM_ZPX};
            8'hB6: d = '{OP_LDX, AM_ZPY};  8'hB8: d = '{OP_CLV, AM_IMP};
            8'hB9: d = '{OP_LDA, AM_ABY};  8'hBA: d = '{OP_TSX, AM_IMP};
            8'hBC: d = '{OP_LDY, AM_ABX};  8'hBD: d = '{OP_LDA, AM_ABX};
            8'hBE: d = '{OP_LDX, AM_ABY};
            8'hC0: d = '{OP_CPY, AM_IMM};  8'hC1: d = '{OP_CMP, AM_IZX};
            8'hC4: d = '{OP_CPY, AM_ZP};   8'hC5: d = '{OP_CMP, AM_ZP};
            8'hC6: d = '{OP_DEC, AM_ZP};   8'hC8: d = '{OP_INY, AM_IMP};
            8'hC9: d = '{OP_CMP, AM_IMM};  8'hCA: d = '{OP_DEX, AM_IMP};
            8'hCC: d = '{OP_CPY, AM_ABS};  8'hCD: d = '{OP_CMP, AM_ABS};
            8'hCE: d = '{OP_DEC, AM_ABS};
            8'hD0: d = '{OP_BNE, AM_REL};  8'hD1: d = '{OP_CMP, AM_IZY};
            8'hD5: d = '{OP_CMP, AM_ZPX};  8'hD6: d = '{OP_DEC, AM_ZPX};
            8'hD8: d = '{OP_CLD, AM_IMP};  8'hD9: d = '{OP_CMP, AM_ABY};
            8'hDD: d = '{OP_CMP, AM_ABX};  8'hDE: d = '{OP_DEC, AM_ABX};
            8'hE0: d = '{OP_CPX, AM_IMM};  8'hE1: d = '{OP_SBC, AM_IZX};
            8'hE4: d = '{OP_CPX, AM_ZP};   8'hE5: d = '{OP_SBC, AM_ZP};
            8'hE6: d = '{OP_INC, AM_ZP};   8'hE8: d = '{OP_INX, AM_IMP};
            8'hE9: d = '{OP_SBC, AM_IMM};  8'hEA: d = '{OP_NOP, AM_IMP};
            8'hEC: d = '{OP_CPX, AM_ABS};  8'hED: d = '{OP_SBC, AM_ABS};
            8'hEE: d = '{OP_INC, AM_ABS};
            8'hF0: d = '{OP_BEQ, AM_REL};  8'hF1: d = '{OP_SBC, AM_IZY};
            8'hF5: d = '{OP_SBC, AM_ZPX};  8'hF6: d = '{OP_INC, AM_ZPX};
            8'hF8: d = '{OP_SED, AM_IMP};  8'hF9: d = '{OP_SBC, AM_ABY};
            8'hFD: d = '{OP_SBC, AM_ABX};  8'hFE: d = '{OP_INC, AM_ABX};
            default: d = '{OP_BAD, AM_IMP};
        endcase
        return d;
    endfunction

endpackage

// File: src/m6502_ram.sv
module m6502_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/m6502_ctrl.sv
module m6502_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_action,
    input  m6502_pkg::t_sts   i_sts,
    output logic              o_in_ready,
    output m6502_pkg::t_cmd   o_cmd
);

    m6502_pkg::t_state r_state, n_state;
    m6502_pkg::t_op    r_op, n_op;
    m6502_pkg::t_mode  r_mode, n_mode;
    m6502_pkg::t_action act;
    logic accept;

    assign act    = m6502_pkg::t_action'(i_action);
    assign accept = i_in_valid && (r_state == m6502_pkg::S_IDLE);

    // Hold state and decoded instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= m6502_pkg::S_CLEAR;
            r_op    <= m6502_pkg::OP_BAD;
            r_mode  <= m6502_pkg::AM_IMP;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_mode  <= n_mode;
        end
    end

    // Latch decode of the opcode word
    always_comb begin
        n_op   = r_op;
        n_mode = r_mode;
        if (r_state == m6502_pkg::S_DEC) begin
            n_op   = i_sts.dec_op;
            n_mode = i_sts.dec_mode;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            m6502_pkg::S_CLEAR: if (i_sts.clr_last) n_state = m6502_pkg::S_IDLE;
            m6502_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (act)
                        m6502_pkg::ACT_WRITE: n_state = m6502_pkg::S_DONE;
                        m6502_pkg::ACT_READ:  n_state = m6502_pkg::S_RDCAP;
                        m6502_pkg::ACT_SETPC: n_state = m6502_pkg::S_DONE;
                        m6502_pkg::ACT_EXEC:  n_state = m6502_pkg::S_DEC;
                    endcase
                end
            end
            m6502_pkg::S_RDCAP: n_state = m6502_pkg::S_DONE;
            m6502_pkg::S_DEC: begin
                priority if (i_sts.dec_op == m6502_pkg::OP_BAD) n_state = m6502_pkg::S_DONE;
                else if (i_sts.dec_mode == m6502_pkg::AM_IMP ||
                         i_sts.dec_mode == m6502_pkg::AM_ACC) n_state = m6502_pkg::S_EXEC;
                else if (i_sts.dec_mode == m6502_pkg::AM_IMM) n_state = m6502_pkg::S_LOAD;
                else n_state = m6502_pkg::S_B1;
            end
            m6502_pkg::S_B1: begin
                priority if (r_mode == m6502_pkg::AM_REL) n_state = m6502_pkg::S_EXEC;
                else if (r_mode == m6502_pkg::AM_ZP || r_mode == m6502_pkg::AM_ZPX ||
                         r_mode == m6502_pkg::AM_ZPY) n_state = m6502_pkg::S_EA;
                else if (r_mode == m6502_pkg::AM_IZX ||
                         r_mode == m6502_pkg::AM_IZY) n_state = m6502_pkg::S_P1;
                else n_state = m6502_pkg::S_B2;
            end
            m6502_pkg::S_B2:
                n_state = (r_mode == m6502_pkg::AM_IND) ? m6502_pkg::S_I1 : m6502_pkg::S_EA;
            m6502_pkg::S_I1: n_state = m6502_pkg::S_I2;
            m6502_pkg::S_I2: n_state = m6502_pkg::S_EA;
            m6502_pkg::S_P1: n_state = m6502_pkg::S_P2;
            m6502_pkg::S_P2: n_state = m6502_pkg::S_EA;
            m6502_pkg::S_EA: begin
                priority if (r_op == m6502_pkg::OP_STA || r_op == m6502_pkg::OP_STX ||
                             r_op == m6502_pkg::OP_STY || r_op == m6502_pkg::OP_JMP)
                    n_state = m6502_pkg::S_DONE;
                else if (r_op == m6502_pkg::OP_JSR) n_state = m6502_pkg::S_JSR2;
                else n_state = m6502_pkg::S_LOAD;
            end
            m6502_pkg::S_LOAD: n_state = m6502_pkg::S_EXEC;
            m6502_pkg::S_EXEC: begin
                priority if (r_op == m6502_pkg::OP_PLA || r_op == m6502_pkg::OP_PLP ||
                             r_op == m6502_pkg::OP_RTS || r_op == m6502_pkg::OP_RTI)
                    n_state = m6502_pkg::S_POP1;
                else if (r_op == m6502_pkg::OP_BRK) n_state = m6502_pkg::S_BRK2;
                else n_state = m6502_pkg::S_DONE;
            end
            m6502_pkg::S_POP1: begin
                priority if (r_op == m6502_pkg::OP_RTI) n_state = m6502_pkg::S_POP2;
                else if (r_op == m6502_pkg::OP_RTS) n_state = m6502_pkg::S_POP3;
                else n_state = m6502_pkg::S_DONE;
            end
            m6502_pkg::S_POP2: n_state = m6502_pkg::S_POP3;
            m6502_pkg::S_POP3: n_state = m6502_pkg::S_DONE;
            m6502_pkg::S_BRK2: n_state = m6502_pkg::S_BRK3;
            m6502_pkg::S_BRK3: n_state = m6502_pkg::S_DONE;
            m6502_pkg::S_JSR2: n_state = m6502_pkg::S_DONE;
            m6502_pkg::S_DONE: if (i_sts.out_free) n_state = m6502_pkg::S_IDLE;
            default: n_state = m6502_pkg::S_CLEAR;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_in_ready = (r_state == m6502_pkg::S_IDLE);
        o_cmd.op   = r_op;
        o_cmd.mode = r_mode;
        o_cmd.uop  = m6502_pkg::U_NONE;
        unique case (r_state)
            m6502_pkg::S_CLEAR: o_cmd.uop = m6502_pkg::U_CLR;
            m6502_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (act)
                        m6502_pkg::ACT_WRITE: o_cmd.uop = m6502_pkg::U_WRITE;
                        m6502_pkg::ACT_READ:  o_cmd.uop = m6502_pkg::U_READ;
                        m6502_pkg::ACT_SETPC: o_cmd.uop = m6502_pkg::U_SETPC;
                        m6502_pkg::ACT_EXEC:  o_cmd.uop = m6502_pkg::U_FETCH;
                    endcase
                end
            end
            m6502_pkg::S_RDCAP: o_cmd.uop = m6502_pkg::U_CAPT;
            m6502_pkg::S_DEC:   o_cmd.uop = m6502_pkg::U_DEC;
            m6502_pkg::S_B1:    o_cmd.uop = m6502_pkg::U_B1;
            m6502_pkg::S_B2:    o_cmd.uop = m6502_pkg::U_B2;
            m6502_pkg::S_I1:    o_cmd.uop = m6502_pkg::U_I1;
            m6502_pkg::S_I2:    o_cmd.uop = m6502_pkg::U_I2;
            m6502_pkg::S_P1:    o_cmd.uop = m6502_pkg::U_P1;
            m6502_pkg::S_P2:    o_cmd.uop = m6502_pkg::U_P2;
            m6502_pkg::S_EA:    o_cmd.uop = m6502_pkg::U_EA;
            m6502_pkg::S_LOAD:  o_cmd.uop = m6502_pkg::U_LOAD;
            m6502_pkg::S_EXEC:  o_cmd.uop = m6502_pkg::U_EXEC;
            m6502_pkg::S_POP1:  o_cmd.uop = m6502_pkg::U_POP1;
            m6502_pkg::S_POP2:  o_cmd.uop = m6502_pkg::U_POP2;
            m6502_pkg::S_POP3:  o_cmd.uop = m6502_pkg::U_POP3;
            m6502_pkg::S_BRK2:  o_cmd.uop = m6502_pkg::U_BRK2;
            m6502_pkg::S_BRK3:  o_cmd.uop = m6502_pkg::U_BRK3;
            m6502_pkg::S_JSR2:  o_cmd.uop = m6502_pkg::U_JSR2;
            m6502_pkg::S_DONE:
                o_cmd.uop = i_sts.out_free ? m6502_pkg::U_OUT : m6502_pkg::U_NONE;
            default: o_cmd.uop = m6502_pkg::U_NONE;
        endcase
    end

endmodule

// File: src/m6502_dp.sv
module m6502_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  m6502_pkg::t_cmd  i_cmd,
    output m6502_pkg::t_sts  o_sts,
    input  logic [15:0]      i_address,
    input  logic [7:0]       i_data,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_read_data,
    output logic [15:0]      o_program_counter,
    output logic [7:0]       o_accumulator,
    output logic [7:0]       o_index_x,
    output logic [7:0]       o_index_y,
    output logic [7:0]       o_stack_pointer,
    output logic [7:0]       o_status,
    output logic             o_invalid_opcode
);

    // Architectural registers
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_sp, n_sp, r_p, n_p;
    logic        r_bug;
    // Scratch registers
    logic [7:0]  r_lo, n_lo, r_opd, n_opd, r_rdata, n_rdata;
    logic [15:0] r_ea, n_ea;
    logic        r_bad, n_bad;
    logic [m6502_pkg::MEM_AW-1:0] r_clr;
    // Output register
    logic        r_ovalid;
    logic [7:0]  r_o_rdata, r_o_a, r_o_x, r_o_y, r_o_sp, r_o_p;
    logic [15:0] r_o_pc;
    logic        r_o_bad;

    // Memory port
    logic [15:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata, q;

    m6502_pkg::t_dec dec;
    logic [7:0]  opv, add_in, res, sh, cmp_reg, zp;
    logic [8:0]  sum, diff;
    logic [15:0] pcm1;
    logic [7:0]  sp_inc, sp_dec;
    logic        c_in, take;

    m6502_ram #(.WIDTH(8), .DEPTH(m6502_pkg::MEM_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr[m6502_pkg::MEM_AW-1:0]),
        .i_wdata (mem_wdata),
        .o_rdata (q)
    );

    assign dec    = m6502_pkg::decode(q);
    assign sp_inc = r_sp + 8'd1;
    assign sp_dec = r_sp - 8'd1;
    assign pcm1   = r_pc - 16'd1;
    assign c_in   = r_p[m6502_pkg::FL_C];
    assign opv    = (i_cmd.mode == m6502_pkg::AM_ACC) ? r_a : r_opd;
    assign zp     = q + r_x;

    // Adder for ADC and SBC, compare for CMP, CPX and CPY, shifter and branch condition
    always_comb begin
        add_in = (i_cmd.op == m6502_pkg::OP_SBC) ? ~opv : opv;
        sum    = {1'b0, r_a} + {1'b0, add_in} + {8'd0, c_in};
        unique case (i_cmd.op)
            m6502_pkg::OP_CPX: cmp_reg = r_x;
            m6502_pkg::OP_CPY: cmp_reg = r_y;
            default:           cmp_reg = r_a;
        endcase
        diff = {1'b0, cmp_reg} - {1'b0, opv};
        unique case (i_cmd.op)
            m6502_pkg::OP_ASL: sh = {opv[6:0], 1'b0};
            m6502_pkg::OP_ROL: sh = {opv[6:0], c_in};
            m6502_pkg::OP_LSR: sh = {1'b0, opv[7:1]};
            default:           sh = {c_in, opv[7:1]};
        endcase
        unique case (i_cmd.op)
            m6502_pkg::OP_BCC: take = !r_p[m6502_pkg::FL_C];
            m6502_pkg::OP_BCS: take =  r_p[m6502_pkg::FL_C];
            m6502_pkg::OP_BNE: take = !r_p[m6502_pkg::FL_Z];
            m6502_pkg::OP_BEQ: take =  r_p[m6502_pkg::FL_Z];
            m6502_pkg::OP_BPL: take = !r_p[m6502_pkg::FL_N];
            m6502_pkg::OP_BMI: take =  r_p[m6502_pkg::FL_N];
            m6502_pkg::OP_BVC: take = !r_p[m6502_pkg::FL_V];
            m6502_pkg::OP_BVS: take =  r_p[m6502_pkg::FL_V];
            default:           take = 1'b0;
        endcase
    end

    // Micro-operation decode: next register values and memory access
    always_comb begin
        n_pc = r_pc; n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p;
        n_lo = r_lo; n_opd = r_opd; n_ea = r_ea; n_bad = r_bad; n_rdata = r_rdata;
        res       = 8'd0;
        mem_addr  = r_ea;
        mem_we    = 1'b0;
        mem_wdata = 8'd0;
        unique case (i_cmd.uop)
            m6502_pkg::U_CLR: begin
                mem_addr = 16'(r_clr);
                mem_we   = 1'b1;
            end
            m6502_pkg::U_WRITE: begin
                n_bad = 1'b0; n_rdata = 8'd0;
                mem_addr = i_address; mem_we = 1'b1; mem_wdata = i_data;
            end
            m6502_pkg::U_READ: begin
                n_bad = 1'b0; n_rdata = 8'd0;
                mem_addr = i_address;
            end
            m6502_pkg::U_SETPC: begin
                n_bad = 1'b0; n_rdata = 8'd0;
                n_pc = i_address;
            end
            m6502_pkg::U_FETCH: begin
                n_bad = 1'b0; n_rdata = 8'd0;
                mem_addr = r_pc; n_pc = r_pc + 16'd1;
            end
            m6502_pkg::U_CAPT: n_rdata = q;
            m6502_pkg::U_DEC: begin
                if (dec.op == m6502_pkg::OP_BAD) begin
                    n_bad = 1'b1;
                end else if (dec.mode != m6502_pkg::AM_IMP &&
                             dec.mode != m6502_pkg::AM_ACC) begin
                    mem_addr = r_pc; n_pc = r_pc + 16'd1;
                end
            end
            m6502_pkg::U_B1: begin
                n_lo = q;
                unique case (i_cmd.mode)
                    m6502_pkg::AM_ZP:  n_ea = {8'd0, q};
                    m6502_pkg::AM_ZPX: n_ea = {8'd0, zp};
                    m6502_pkg::AM_ZPY: n_ea = {8'd0, q + r_y};
                    m6502_pkg::AM_REL: n_ea = r_pc + {{8{q[7]}}, q};
                    m6502_pkg::AM_IZX: begin
                        n_lo = zp; mem_addr = {8'd0, zp};
                    end
                    m6502_pkg::AM_IZY: mem_addr = {8'd0, q};
                    default: begin
                        mem_addr = r_pc; n_pc = r_pc + 16'd1;
                    end
                endcase
            end
            m6502_pkg::U_B2: begin
                unique case (i_cmd.mode)
                    m6502_pkg::AM_ABX: n_ea = {q, r_lo} + {8'd0, r_x};
                    m6502_pkg::AM_ABY: n_ea = {q, r_lo} + {8'd0, r_y};
                    m6502_pkg::AM_IND: begin
                        n_ea = {q, r_lo}; mem_addr = {q, r_lo};
                    end
                    default: n_ea = {q, r_lo};
                endcase
            end
            m6502_pkg::U_I1: begin
                n_lo = q;
                // keep the pointer within its page when the bug is on
                mem_addr = (r_bug && r_ea[7:0] == 8'hFF) ? {r_ea[15:8], 8'h00}
                                                         : r_ea + 16'd1;
            end
            m6502_pkg::U_I2: n_ea = {q, r_lo};
            m6502_pkg::U_P1: begin
                n_opd = q;
                mem_addr = {8'd0, r_lo + 8'd1};
            end
            m6502_pkg::U_P2: begin
                n_ea = {q, r_opd} +
                       ((i_cmd.mode == m6502_pkg::AM_IZY) ? {8'd0, r_y} : 16'd0);
            end
            m6502_pkg::U_EA: begin
                unique case (i_cmd.op)
                    m6502_pkg::OP_STA: begin mem_we = 1'b1; mem_wdata = r_a; end
                    m6502_pkg::OP_STX: begin mem_we = 1'b1; mem_wdata = r_x; end
                    m6502_pkg::OP_STY: begin mem_we = 1'b1; mem_wdata = r_y; end
                    m6502_pkg::OP_JMP: n_pc = r_ea;
                    m6502_pkg::OP_JSR: begin
                        mem_addr = {m6502_pkg::STACK_PAGE, r_sp};
                        mem_we = 1'b1; mem_wdata = pcm1[15:8]; n_sp = sp_dec;
                    end
                    default: mem_addr = r_ea;
                endcase
            end
            m6502_pkg::U_LOAD: n_opd = q;
            m6502_pkg::U_JSR2: begin
                mem_addr = {m6502_pkg::STACK_PAGE, r_sp};
                mem_we = 1'b1; mem_wdata = pcm1[7:0]; n_sp = sp_dec;
                n_pc = r_ea;
            end
            m6502_pkg::U_EXEC: begin
                unique case (i_cmd.op)
                    m6502_pkg::OP_ADC, m6502_pkg::OP_SBC: begin
                        res = sum[7:0];
                        n_a = res;
                        n_p[m6502_pkg::FL_C] = sum[8];
                        n_p[m6502_pkg::FL_V] = (r_a[7] ^ res[7]) & (add_in[7] ^ res[7]);
                    end
                    m6502_pkg::OP_AND: begin res = r_a & opv; n_a = res; end
                    m6502_pkg::OP_ORA: begin res = r_a | opv; n_a = res; end
                    m6502_pkg::OP_EOR: begin res = r_a ^ opv; n_a = res; end
                    m6502_pkg::OP_ASL, m6502_pkg::OP_ROL, m6502_pkg::OP_LSR,
                    m6502_pkg::OP_ROR: begin
                        res = sh;
                        n_p[m6502_pkg::FL_C] = (i_cmd.op == m6502_pkg::OP_ASL ||
                                                i_cmd.op == m6502_pkg::OP_ROL) ? opv[7] : opv[0];
                        if (i_cmd.mode == m6502_pkg::AM_ACC) begin
                            n_a = sh;
                        end else begin
                            mem_we = 1'b1; mem_wdata = sh;
                        end
                    end
                    m6502_pkg::OP_INC: begin res = opv + 8'd1; mem_we = 1'b1; mem_wdata = res; end
                    m6502_pkg::OP_DEC: begin res = opv - 8'd1; mem_we = 1'b1; mem_wdata = res; end
                    m6502_pkg::OP_CMP, m6502_pkg::OP_CPX, m6502_pkg::OP_CPY: begin
                        res = diff[7:0];
                        n_p[m6502_pkg::FL_C] = !diff[8];
                    end
                    m6502_pkg::OP_BIT: begin
                        res = r_a & opv;
                        n_p[m6502_pkg::FL_V] = opv[6];
                    end
                    m6502_pkg::OP_LDA: begin res = opv; n_a = res; end
                    m6502_pkg::OP_LDX: begin res = opv; n_x = res; end
                    m6502_pkg::OP_LDY: begin res = opv; n_y = res; end
                    m6502_pkg::OP_DEX: begin res = r_x - 8'd1; n_x = res; end
                    m6502_pkg::OP_DEY: begin res = r_y - 8'd1; n_y = res; end
                    m6502_pkg::OP_INX: begin res = r_x + 8'd1; n_x = res; end
                    m6502_pkg::OP_INY: begin res = r_y + 8'd1; n_y = res; end
                    m6502_pkg::OP_TAX: begin res = r_a; n_x = res; end
                    m6502_pkg::OP_TAY: begin res = r_a; n_y = res; end
                    m6502_pkg::OP_TSX: begin res = r_sp; n_x = res; end
                    m6502_pkg::OP_TXA: begin res = r_x; n_a = res; end
                    m6502_pkg::OP_TYA: begin res = r_y; n_a = res; end
                    m6502_pkg::OP_TXS: n_sp = r_x;
                    m6502_pkg::OP_CLC: n_p[m6502_pkg::FL_C] = 1'b0;
                    m6502_pkg::OP_CLD: n_p[m6502_pkg::FL_D] = 1'b0;
                    m6502_pkg::OP_CLI: n_p[m6502_pkg::FL_I] = 1'b0;
                    m6502_pkg::OP_CLV: n_p[m6502_pkg::FL_V] = 1'b0;
                    m6502_pkg::OP_SEC: n_p[m6502_pkg::FL_C] = 1'b1;
                    m6502_pkg::OP_SED: n_p[m6502_pkg::FL_D] = 1'b1;
                    m6502_pkg::OP_SEI: n_p[m6502_pkg::FL_I] = 1'b1;
                    m6502_pkg::OP_PHA, m6502_pkg::OP_PHP: begin
                        mem_addr = {m6502_pkg::STACK_PAGE, r_sp};
                        mem_we = 1'b1; n_sp = sp_dec;
                        mem_wdata = (i_cmd.op == m6502_pkg::OP_PHA) ? r_a : (r_p | 8'h30);
                    end
                    m6502_pkg::OP_PLA, m6502_pkg::OP_PLP, m6502_pkg::OP_RTS,
                    m6502_pkg::OP_RTI: begin
                        mem_addr = {m6502_pkg::STACK_PAGE, sp_inc};
                        n_sp = sp_inc;
                    end
                    m6502_pkg::OP_BRK: begin
                        n_p[m6502_pkg::FL_I] = 1'b1;
                        mem_addr = {m6502_pkg::STACK_PAGE, r_sp};
                        mem_we = 1'b1; mem_wdata = r_pc[15:8]; n_sp = sp_dec;
                    end
                    default: ;
                endcase
                // Update N and Z for the ops that produce a result byte
                unique case (i_cmd.op)
                    m6502_pkg::OP_ADC, m6502_pkg::OP_SBC, m6502_pkg::OP_AND,
                    m6502_pkg::OP_ORA, m6502_pkg::OP_EOR, m6502_pkg::OP_ASL,
                    m6502_pkg::OP_ROL, m6502_pkg::OP_LSR, m6502_pkg::OP_ROR,
                    m6502_pkg::OP_INC, m6502_pkg::OP_DEC, m6502_pkg::OP_LDA,
                    m6502_pkg::OP_LDX, m6502_pkg::OP_LDY, m6502_pkg::OP_DEX,
                    m6502_pkg::OP_DEY, m6502_pkg::OP_INX, m6502_pkg::OP_INY,
                    m6502_pkg::OP_TAX, m6502_pkg::OP_TAY, m6502_pkg::OP_TSX,
                    m6502_pkg::OP_TXA, m6502_pkg::OP_TYA: begin
                        n_p[m6502_pkg::FL_Z] = (res == 8'd0);
                        n_p[m6502_pkg::FL_N] = res[7];
                    end
                    m6502_pkg::OP_CMP, m6502_pkg::OP_CPX, m6502_pkg::OP_CPY: begin
                        n_p[m6502_pkg::FL_Z] = (cmp_reg == opv);
                        n_p[m6502_pkg::FL_N] = res[7];
                    end
                    m6502_pkg::OP_BIT: begin
                        n_p[m6502_pkg::FL_Z] = (res == 8'd0);
                        n_p[m6502_pkg::FL_N] = opv[7];
                    end
                    default: ;
                endcase
                if (take) begin
                    n_pc = r_ea;
                end
            end
            m6502_pkg::U_POP1: begin
                unique case (i_cmd.op)
                    m6502_pkg::OP_PLA: begin
                        n_a = q;
                        n_p[m6502_pkg::FL_Z] = (q == 8'd0);
                        n_p[m6502_pkg::FL_N] = q[7];
                    end
                    m6502_pkg::OP_RTS: begin
                        n_lo = q;
                        mem_addr = {m6502_pkg::STACK_PAGE, sp_inc}; n_sp = sp_inc;
                    end
                    m6502_pkg::OP_RTI: begin
                        n_p = (q | 8'h20) & 8'hEF;
                        mem_addr = {m6502_pkg::STACK_PAGE, sp_inc}; n_sp = sp_inc;
                    end
                    default: n_p = (q | 8'h20) & 8'hEF;
                endcase
            end
            m6502_pkg::U_POP2: begin
                n_lo = q;
                mem_addr = {m6502_pkg::STACK_PAGE, sp_inc}; n_sp = sp_inc;
            end
            m6502_pkg::U_POP3: begin
                n_pc = {q, r_lo} + ((i_cmd.op == m6502_pkg::OP_RTS) ? 16'd1 : 16'd0);
            end
            m6502_pkg::U_BRK2: begin
                mem_addr = {m6502_pkg::STACK_PAGE, r_sp};
                mem_we = 1'b1; mem_wdata = r_pc[7:0]; n_sp = sp_dec;
            end
            m6502_pkg::U_BRK3: begin
                mem_addr = {m6502_pkg::STACK_PAGE, r_sp};
                mem_we = 1'b1; mem_wdata = r_p | 8'h20; n_sp = sp_dec;
            end
            default: ;
        endcase
    end

    // Advance architectural and scratch registers; configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= m6502_pkg::RST_PC;
            r_a   <= 8'd0;
            r_x   <= 8'd0;
            r_y   <= 8'd0;
            r_sp  <= m6502_pkg::RST_SP;
            r_p   <= m6502_pkg::RST_STATUS;
            r_bug <= 1'b1;
            r_bad <= 1'b0;
            r_rdata <= 8'd0;
            r_clr <= '0;
        end else begin
            r_pc  <= n_pc;
            r_a   <= n_a;
            r_x   <= n_x;
            r_y   <= n_y;
            r_sp  <= n_sp;
            r_p   <= n_p;
            r_bad <= n_bad;
            r_rdata <= n_rdata;
            if (i_cmd.uop == m6502_pkg::U_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    m6502_pkg::CFG_JMP_BUG: r_bug <= i_cfg_data[0];
                    m6502_pkg::CFG_START:   r_pc  <= i_cfg_data;
                    m6502_pkg::CFG_STACK:   r_sp  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_opd <= n_opd;
        r_ea  <= n_ea;
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.uop == m6502_pkg::U_OUT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == m6502_pkg::U_OUT) begin
            r_o_rdata <= r_rdata;
            r_o_pc    <= r_pc;
            r_o_a     <= r_a;
            r_o_x     <= r_x;
            r_o_y     <= r_y;
            r_o_sp    <= r_sp;
            r_o_p     <= r_p | 8'h20;
            r_o_bad   <= r_bad;
        end
    end

    assign o_sts.dec_op   = dec.op;
    assign o_sts.dec_mode = dec.mode;
    assign o_sts.clr_last = (r_clr == {m6502_pkg::MEM_AW{1'b1}});
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid       = r_ovalid;
    assign o_read_data       = r_o_rdata;
    assign o_program_counter = r_o_pc;
    assign o_accumulator     = r_o_a;
    assign o_index_x         = r_o_x;
    assign o_index_y         = r_o_y;
    assign o_stack_pointer   = r_o_sp;
    assign o_status          = r_o_p;
    assign o_invalid_opcode  = r_o_bad;

endmodule

// File: src/mos6502_instruction_core.sv
// 6502 instruction core with a private 64 KiB byte memory.
// Input channel (i_in_valid / o_in_ready): one word per action: write a memory
// byte, read a memory byte, load the program counter, or execute one instruction.
// Output channel (o_out_valid / i_out_ready): one word per action with the read
// byte and the register file after the action.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 indirect jump page bug,
// 1 start address (also loads pc), 2 initial stack (also loads sp); always ready.
// Each access on the single-port memory takes its own controller state (opcode,
// operand bytes, pointer bytes, stack bytes, read-modify-write).
// One action is worked on at a time; the next is taken once the result sits in
// the output register, even while the receiver still stalls it. A second result
// waits in the controller until the output register frees up.
// Reset: registers take their reset values, then a clearing pass zeroes the
// memory, one byte a cycle over its 65536 bytes, with the input channel not ready.
module mos6502_instruction_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_program_counter,
    output logic [7:0]  o_accumulator,
    output logic [7:0]  o_index_x,
    output logic [7:0]  o_index_y,
    output logic [7:0]  o_stack_pointer,
    output logic [7:0]  o_status,
    output logic        o_invalid_opcode,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    m6502_pkg::t_cmd cmd;
    m6502_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    m6502_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    m6502_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_address         (i_address),
        .i_data            (i_data),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_read_data       (o_read_data),
        .o_program_counter (o_program_counter),
        .o_accumulator     (o_accumulator),
        .o_index_x         (o_index_x),
        .o_index_y         (o_index_y),
        .o_stack_pointer   (o_stack_pointer),
        .o_status          (o_status),
        .o_invalid_opcode  (o_invalid_opcode)
    );

endmodule

// File: tb/sv/mos6502_instruction_core_tb.sv
`timescale 1ns / 100ps

module mos6502_instruction_core_tb;
    import m6502_pkg::*;

    localparam int IDLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 12;
    localparam int LONG_HOLD = 400;

    typedef struct {
        t_action     act;
        logic [15:0] addr;
        logic [7:0]  data;
        bit          drain;
    } action_word_t;

    typedef struct {
        logic [7:0]  rdata;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  ix;
        logic [7:0]  iy;
        logic [7:0]  sp;
        logic [7:0]  st;
        logic        bad;
    } cpu_view_t;

    typedef struct packed {
        t_op   op;
        t_mode md;
    } opcode_info_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_action = 2'd0;
    logic [15:0] i_address = 16'd0;
    logic [7:0]  i_data = 8'd0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data = 16'd0;
    logic        o_in_ready, o_out_valid, o_cfg_ready, o_invalid_opcode;
    logic [7:0]  o_read_data, o_accumulator, o_index_x, o_index_y;
    logic [7:0]  o_stack_pointer, o_status;
    logic [15:0] o_program_counter;

    mos6502_instruction_core dut (.*);

    always #5 i_clk = ~i_clk;

    // CPU shadow state
    logic [7:0]  cpu_mem [0:65535];
    logic [15:0] cpu_pc;
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    logic        cpu_jmp_bug;

    action_word_t action_q[$];
    cpu_view_t    expected_regs_q[$];
    action_word_t cur_word;

    int  err_cnt = 0;
    int  n_sent = 0;
    int  n_exec = 0;
    int  n_bad = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    int  stall_mode = 0;
    int  mon_cycles = 0;
    int  idle_cycles = 0;
    bit  hold_req = 1'b0;
    bit  hold_seen = 1'b0;

    // Opcode table
    function automatic opcode_info_t decode_op(input logic [7:0] opc);
        opcode_info_t d;
        d = '{OP_BAD, AM_IMP};
        if (opc[1:0] == 2'b01) begin
            case (opc[7:5])
                3'd0: d.op = OP_ORA;
                3'd1: d.op = OP_AND;
                3'd2: d.op = OP_EOR;
                3'd3: d.op = OP_ADC;
                3'd4: d.op = OP_STA;
                3'd5: d.op = OP_LDA;
                3'd6: d.op = OP_CMP;
                default: d.op = OP_SBC;
            endcase
            case (opc[4:2])
                3'd0: d.md = AM_IZX;
                3'd1: d.md = AM_ZP;
                3'd2: d.md = AM_IMM;
                3'd3: d.md = AM_ABS;
                3'd4: d.md = AM_IZY;
                3'd5: d.md = AM_ZPX;
                3'd6: d.md = AM_ABY;
                default: d.md = AM_ABX;
            endcase
            if (opc == 8'h89) d = '{OP_BAD, AM_IMP};
        end else if (opc[1:0] == 2'b10) begin
            case (opc[7:5])
                3'd0: d.op = OP_ASL;
                3'd1: d.op = OP_ROL;
                3'd2: d.op = OP_LSR;
                3'd3: d.op = OP_ROR;
                3'd4: d.op = OP_STX;
                3'd5: d.op = OP_LDX;
                3'd6: d.op = OP_DEC;
                default: d.op = OP_INC;
            endcase
            case (opc[4:2])
                3'd1: d.md = AM_ZP;
                3'd3: d.md = AM_ABS;
                3'd5: d.md = (opc[7:6] == 2'b10) ? AM_ZPY : AM_ZPX;
                3'd7: d.md = (opc == 8'hBE) ? AM_ABY : AM_ABX;
                default: d.md = AM_IMP;
            endcase
            if (opc == 8'h9E) d = '{OP_BAD, AM_IMP};
            if (opc[4:2] == 3'd0) d = (opc == 8'hA2) ? '{OP_LDX, AM_IMM} : '{OP_BAD, AM_IMP};
            if (opc[4:2] == 3'd4 || opc[4:2] == 3'd6) d = '{OP_BAD, AM_IMP};
            if (opc[4:2] == 3'd2) begin
                case (opc)
                    8'h8A: d = '{OP_TXA, AM_IMP};
                    8'hAA: d = '{OP_TAX, AM_IMP};
                    8'hCA: d = '{OP_DEX, AM_IMP};
                    8'hEA: d = '{OP_NOP, AM_IMP};
                    default: d.md = opc[7] ? AM_IMP : AM_ACC;
                endcase
                if (opc[7] && opc != 8'h8A && opc != 8'hAA && opc != 8'hCA && opc != 8'hEA)
                    d = '{OP_BAD, AM_IMP};
            end
            if (opc == 8'h9A) d = '{OP_TXS, AM_IMP};
            if (opc == 8'hBA) d = '{OP_TSX, AM_IMP};
        end else if (opc[1:0] == 2'b00) begin
            case (opc)
                8'h00: d = '{OP_BRK, AM_IMP};  8'h08: d = '{OP_PHP, AM_IMP};
                8'h10: d = '{OP_BPL, AM_REL};  8'h18: d = '{OP_CLC, AM_IMP};
                8'h20: d = '{OP_JSR, AM_ABS};  8'h24: d = '{OP_BIT, AM_ZP};
                8'h28: d = '{OP_PLP, AM_IMP};  8'h2C: d = '{OP_BIT, AM_ABS};
                8'h30: d = '{OP_BMI, AM_REL};  8'h38: d = '{OP_SEC, AM_IMP};
                8'h40: d = '{OP_RTI, AM_IMP};  8'h48: d = '{OP_PHA, AM_IMP};
                8'h4C: d = '{OP_JMP, AM_ABS};  8'h50: d = '{OP_BVC, AM_REL};
                8'h58: d = '{OP_CLI, AM_IMP};  8'h60: d = '{OP_RTS, AM_IMP};
                8'h68: d = '{OP_PLA, AM_IMP};  8'h6C: d = '{OP_JMP, AM_IND};
                8'h70: d = '{OP_BVS, AM_REL};  8'h78: d = '{OP_SEI, AM_IMP};
                8'h84: d = '{OP_STY, AM_ZP};   8'h88: d = '{OP_DEY, AM_IMP};
                8'h8C: d = '{OP_STY, AM_ABS};  8'h90: d = '{OP_BCC, AM_REL};
                8'h94: d = '{OP_STY, AM_ZPX};  8'h98: d = '{OP_TYA, AM_IMP};
                8'hA0: d = '{OP_LDY, AM_IMM};  8'hA4: d = '{OP_LDY, AM_ZP};
                8'hA8: d = '{OP_TAY, AM_IMP};  8'hAC: d = '{OP_LDY, AM_ABS};
                8'hB0: d = '{OP_BCS, AM_REL};  8'hB4: d = '{OP_LDY, AM_ZPX};
                8'hB8: d = '{OP_CLV, AM_IMP};  8'hBC: d = '{OP_LDY, AM_ABX};
                8'hC0: d = '{OP_CPY, AM_IMM};  8'hC4: d = '{OP_CPY, AM_ZP};
                8'hC8: d = '{OP_INY, AM_IMP};  8'hCC: d = '{OP_CPY, AM_ABS};
                8'hD0: d = '{OP_BNE, AM_REL};  8'hD8: d = '{OP_CLD, AM_IMP};
                8'hE0: d = '{OP_CPX, AM_IMM};  8'hE4: d = '{OP_CPX, AM_ZP};
                8'hE8: d = '{OP_INX, AM_IMP};  8'hEC: d = '{OP_CPX, AM_ABS};
                8'hF0: d = '{OP_BEQ, AM_REL};  8'hF8: d = '{OP_SED, AM_IMP};
                default: d = '{OP_BAD, AM_IMP};
            endcase
        end
        return d;
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] b;
        b = cpu_mem[cpu_pc];
        cpu_pc = cpu_pc + 16'd1;
        return b;
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [7:0] lo, hi;
        lo = fetch_byte();
        hi = fetch_byte();
        return {hi, lo};
    endfunction

    // Pointer read that wraps within page zero
    function automatic logic [15:0] zp_word(input logic [7:0] z);
        logic [7:0] z1;
        z1 = z + 8'd1;
        return {cpu_mem[{8'h00, z1}], cpu_mem[{8'h00, z}]};
    endfunction

    task automatic set_nz(input logic [7:0] v);
        cpu_p[FL_Z] = (v == 8'd0);
        cpu_p[FL_N] = v[7];
    endtask

    task automatic push_byte(input logic [7:0] v);
        cpu_mem[{STACK_PAGE, cpu_sp}] = v;
        cpu_sp = cpu_sp - 8'd1;
    endtask

    function automatic logic [7:0] pop_byte();
        cpu_sp = cpu_sp + 8'd1;
        return cpu_mem[{STACK_PAGE, cpu_sp}];
    endfunction

    task automatic pull_status();
        cpu_p = pop_byte() | 8'h20;
        cpu_p[FL_B] = 1'b0;
    endtask

    task automatic add_carry(input logic [7:0] v);
        logic [8:0] sum;
        sum = {1'b0, cpu_a} + {1'b0, v} + {8'd0, cpu_p[FL_C]};
        cpu_p[FL_C] = sum[8];
        cpu_p[FL_V] = ((cpu_a ^ sum[7:0]) & (v ^ sum[7:0]) & 8'h80) != 8'd0;
        set_nz(sum[7:0]);
        cpu_a = sum[7:0];
    endtask

    task automatic compare(input logic [7:0] r, input logic [7:0] v);
        logic [7:0] diff;
        diff = r - v;
        cpu_p[FL_Z] = (r == v);
        cpu_p[FL_C] = (r >= v);
        cpu_p[FL_N] = diff[7];
    endtask

    // Fetch, address and execute one instruction
    task automatic run_instr(output logic bad);
        opcode_info_t d;
        logic [7:0]  opc, imm, v, r, lo, hi, src;
        logic [15:0] ea, p, pa;
        logic        c, take;
        opc = fetch_byte();
        d = decode_op(opc);
        bad = 1'b0;
        take = 1'b0;
        imm = 8'd0;
        ea = 16'd0;
        c = cpu_p[FL_C];
        if (d.op == OP_BAD) begin
            bad = 1'b1;
            return;
        end
        case (d.md)
            AM_IMM: imm = fetch_byte();
            AM_ZP: ea = {8'h00, fetch_byte()};
            AM_ZPX: begin
                lo = fetch_byte() + cpu_x;
                ea = {8'h00, lo};
            end
            AM_ZPY: begin
                lo = fetch_byte() + cpu_y;
                ea = {8'h00, lo};
            end
            AM_ABS: ea = fetch_word();
            AM_ABX: ea = fetch_word() + {8'h00, cpu_x};
            AM_ABY: ea = fetch_word() + {8'h00, cpu_y};
            AM_IND: begin
                p = fetch_word();
                pa = (cpu_jmp_bug && p[7:0] == 8'hFF) ? {p[15:8], 8'h00} : p + 16'd1;
                ea = {cpu_mem[pa], cpu_mem[p]};
            end
            AM_IZX: begin
                lo = fetch_byte() + cpu_x;
                ea = zp_word(lo);
            end
            AM_IZY: begin
                lo = fetch_byte();
                ea = zp_word(lo) + {8'h00, cpu_y};
            end
            AM_REL: begin
                v = fetch_byte();
                ea = cpu_pc + {{8{v[7]}}, v};
            end
            default: ;
        endcase
        src = (d.md == AM_ACC) ? cpu_a : (d.md == AM_IMM) ? imm : cpu_mem[ea];
        case (d.op)
            OP_ADC: add_carry(src);
            OP_SBC: add_carry(~src);
            OP_AND: begin cpu_a = cpu_a & src; set_nz(cpu_a); end
            OP_ORA: begin cpu_a = cpu_a | src; set_nz(cpu_a); end
            OP_EOR: begin cpu_a = cpu_a ^ src; set_nz(cpu_a); end
            OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
                if (d.op == OP_ASL || d.op == OP_ROL) begin
                    r = {src[6:0], (d.op == OP_ROL) & c};
                    cpu_p[FL_C] = src[7];
                end else begin
                    r = {(d.op == OP_ROR) & c, src[7:1]};
                    cpu_p[FL_C] = src[0];
                end
                set_nz(r);
                if (d.md == AM_ACC) cpu_a = r;
                else cpu_mem[ea] = r;
            end
            OP_BCC: take = !cpu_p[FL_C];
            OP_BCS: take = cpu_p[FL_C];
            OP_BNE: take = !cpu_p[FL_Z];
            OP_BEQ: take = cpu_p[FL_Z];
            OP_BPL: take = !cpu_p[FL_N];
            OP_BMI: take = cpu_p[FL_N];
            OP_BVC: take = !cpu_p[FL_V];
            OP_BVS: take = cpu_p[FL_V];
            OP_BIT: begin
                cpu_p[FL_Z] = (src & cpu_a) == 8'd0;
                cpu_p[FL_V] = src[6];
                cpu_p[FL_N] = src[7];
            end
            OP_BRK: begin
                cpu_p[FL_I] = 1'b1;
                push_byte(cpu_pc[15:8]);
                push_byte(cpu_pc[7:0]);
                push_byte(cpu_p);
            end
            OP_CLC: cpu_p[FL_C] = 1'b0;
            OP_CLD: cpu_p[FL_D] = 1'b0;
            OP_CLI: cpu_p[FL_I] = 1'b0;
            OP_CLV: cpu_p[FL_V] = 1'b0;
            OP_SEC: cpu_p[FL_C] = 1'b1;
            OP_SED: cpu_p[FL_D] = 1'b1;
            OP_SEI: cpu_p[FL_I] = 1'b1;
            OP_CMP: compare(cpu_a, src);
            OP_CPX: compare(cpu_x, src);
            OP_CPY: compare(cpu_y, src);
            OP_DEC: begin r = cpu_mem[ea] - 8'd1; set_nz(r); cpu_mem[ea] = r; end
            OP_INC: begin r = cpu_mem[ea] + 8'd1; set_nz(r); cpu_mem[ea] = r; end
            OP_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
            OP_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
            OP_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
            OP_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
            OP_JMP: cpu_pc = ea;
            OP_JSR: begin
                p = cpu_pc - 16'd1;
                push_byte(p[15:8]);
                push_byte(p[7:0]);
                cpu_pc = ea;
            end
            OP_LDA: begin cpu_a = src; set_nz(cpu_a); end
            OP_LDX: begin cpu_x = src; set_nz(cpu_x); end
            OP_LDY: begin cpu_y = src; set_nz(cpu_y); end
            OP_PHA: push_byte(cpu_a);
            OP_PHP: push_byte(cpu_p | 8'h10);
            OP_PLA: begin cpu_a = pop_byte(); set_nz(cpu_a); end
            OP_PLP: pull_status();
            OP_RTI: begin
                pull_status();
                lo = pop_byte();
                hi = pop_byte();
                cpu_pc = {hi, lo};
            end
            OP_RTS: begin
                lo = pop_byte();
                hi = pop_byte();
                cpu_pc = {hi, lo} + 16'd1;
            end
            OP_STA: cpu_mem[ea] = cpu_a;
            OP_STX: cpu_mem[ea] = cpu_x;
            OP_STY: cpu_mem[ea] = cpu_y;
            OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
            OP_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
            OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
            OP_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
            OP_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
            OP_TXS: cpu_sp = cpu_x;
            default: ;
        endcase
        if (take) cpu_pc = ea;
    endtask

    // Apply one accepted word to the shadow CPU and queue the register view
    task automatic predict_action(input action_word_t w);
        cpu_view_t e;
        logic      bad;
        e.rdata = 8'd0;
        bad = 1'b0;
        case (w.act)
            ACT_WRITE: cpu_mem[w.addr] = w.data;
            ACT_READ:  e.rdata = cpu_mem[w.addr];
            ACT_SETPC: cpu_pc = w.addr;
            default: begin
                run_instr(bad);
                n_exec++;
                if (bad) n_bad++;
            end
        endcase
        e.pc = cpu_pc;
        e.acc = cpu_a;
        e.ix = cpu_x;
        e.iy = cpu_y;
        e.sp = cpu_sp;
        e.st = cpu_p | 8'h20;
        e.bad = bad;
        expected_regs_q.push_back(e);
    endtask

    // Driver: bursts of words with random gaps; a drain word waits for all results
    always @(posedge i_clk) begin
        logic nv;
        nv = i_in_valid;
        if (i_in_valid && o_in_ready) begin
            predict_action(cur_word);
            n_sent++;
            nv = 1'b0;
        end
        if (!nv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (action_q.size() != 0 &&
                         (!action_q[0].drain || expected_regs_q.size() == 0)) begin
                cur_word = action_q.pop_front();
                i_action <= cur_word.act;
                i_address <= cur_word.addr;
                i_data <= cur_word.data;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 6);
                end
            end
        end
        i_in_valid <= nv;
    end

    task automatic check_field(input string nm, input logic [15:0] e, input logic [15:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
            err_cnt++;
        end
    endtask

    // Monitor: stall pattern, long hold on request, and result checking
    always @(posedge i_clk) begin
        cpu_view_t e;
        logic nr;
        mon_cycles++;
        if (mon_cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
        if (i_out_ready && o_out_valid) begin
            if (expected_regs_q.size() == 0) begin
                $display("%0t: result word with nothing expected, pc %h", $time,
                         o_program_counter);
                err_cnt++;
            end else begin
                e = expected_regs_q.pop_front();
                check_field("read_data", e.rdata, o_read_data);
                check_field("program_counter", e.pc, o_program_counter);
                check_field("accumulator", e.acc, o_accumulator);
                check_field("index_x", e.ix, o_index_x);
                check_field("index_y", e.iy, o_index_y);
                check_field("stack_pointer", e.sp, o_stack_pointer);
                check_field("status", e.st, o_status);
                check_field("invalid_opcode", e.bad, o_invalid_opcode);
            end
        end
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (stall_mode == 0) begin
            nr = 1'b1;
        end else if (stall_mode == 1) begin
            nr = $urandom_range(0, 1);
        end else begin
            nr = ($urandom_range(0, 3) == 0);
        end
        i_out_ready <= nr;
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("mos6502_instruction_core test failed");
                $finish;
            end
        end
    end

    task automatic add_word(input t_action a, input logic [15:0] addr, input logic [7:0] d,
                            input bit drain);
        action_word_t w;
        w.act = a;
        w.addr = addr;
        w.data = d;
        w.drain = drain;
        action_q.push_back(w);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_JMP_BUG: cpu_jmp_bug = val[0];
            CFG_START: cpu_pc = val;
            CFG_STACK: cpu_sp = val[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (action_q.size() != 0 || i_in_valid || expected_regs_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] good_opcode();
        logic [7:0] o;
        do o = $urandom_range(0, 255); while (decode_op(o).op == OP_BAD);
        return o;
    endfunction

    // Random programs: load bytes, point pc at them, run; plus reads and noise
    task automatic gen_random(input int count, input bit drains);
        int          added, len, sel;
        logic [15:0] base, a;
        added = 0;
        while (added < count) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                case ($urandom_range(0, 3))
                    0: base = $urandom_range(0, 16'hFFFF);
                    1: base = $urandom_range(16'h0200, 16'h02F0);
                    2: base = 16'hFFF8 + $urandom_range(0, 7);
                    default: base = $urandom_range(0, 16'h00F0);
                endcase
                len = $urandom_range(2, 10);
                add_word(ACT_WRITE, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
                add_word(ACT_WRITE, {8'h01, 8'($urandom_range(0, 255))},
                         $urandom_range(0, 255), 1'b0);
                for (int k = 0; k < len; k++)
                    add_word(ACT_WRITE, base + k[15:0],
                             $urandom_range(0, 1) ? good_opcode() : 8'($urandom_range(0, 255)),
                             1'b0);
                add_word(ACT_SETPC, base, $urandom_range(0, 255), 1'b0);
                len = $urandom_range(1, len);
                for (int k = 0; k < len; k++)
                    add_word(ACT_EXEC, $urandom_range(0, 16'hFFFF), $urandom_range(0, 255),
                             drains && $urandom_range(0, 29) == 0);
                added += 4 + len + len;
            end else if (sel < 80) begin
                a = $urandom_range(0, 2) == 0 ? $urandom_range(0, 16'hFFFF) :
                    {7'd0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))};
                add_word(ACT_READ, a, $urandom_range(0, 255), 1'b0);
                added++;
            end else if (sel < 90) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    add_word(ACT_EXEC, $urandom_range(0, 16'hFFFF), $urandom_range(0, 255),
                             1'b0);
                added += len;
            end else begin
                add_word(t_action'($urandom_range(0, 3)), $urandom_range(0, 16'hFFFF),
                         $urandom_range(0, 255), drains && $urandom_range(0, 9) == 0);
                added++;
            end
        end
    endtask

    // Sequence: reset, directed checks, then random phases under changing settings
    initial begin
        for (int k = 0; k < 65536; k++) cpu_mem[k] = 8'd0;
        cpu_pc = RST_PC;
        cpu_sp = RST_SP;
        cpu_a = 8'd0;
        cpu_x = 8'd0;
        cpu_y = 8'd0;
        cpu_p = RST_STATUS;
        cpu_jmp_bug = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);

        cfg_write(CFG_JMP_BUG, 16'd1);
        cfg_write(CFG_START, 16'h0600);
        cfg_write(CFG_STACK, 16'h00FF);
        cfg_write(2'd3, 16'hFFFF);

        // Field extremes, undefined opcode with pc wrap, then BRK at address zero
        add_word(ACT_WRITE, 16'hFFFF, 8'hFF, 1'b0);
        add_word(ACT_READ, 16'hFFFF, 8'h00, 1'b0);
        add_word(ACT_WRITE, 16'h0000, 8'h00, 1'b0);
        add_word(ACT_READ, 16'h0000, 8'hFF, 1'b0);
        add_word(ACT_SETPC, 16'hFFFF, 8'h00, 1'b0);
        add_word(ACT_EXEC, 16'h0000, 8'h00, 1'b0);
        add_word(ACT_EXEC, 16'hFFFF, 8'hFF, 1'b0);
        // LDA #1, ADC #FF carries out to zero, BEQ back with a negative offset
        add_word(ACT_WRITE, 16'h0200, 8'hA9, 1'b0);
        add_word(ACT_WRITE, 16'h0201, 8'h01, 1'b0);
        add_word(ACT_WRITE, 16'h0202, 8'h69, 1'b0);
        add_word(ACT_WRITE, 16'h0203, 8'hFF, 1'b0);
        add_word(ACT_WRITE, 16'h0204, 8'hF0, 1'b0);
        add_word(ACT_WRITE, 16'h0205, 8'hFA, 1'b0);
        add_word(ACT_SETPC, 16'h0200, 8'h00, 1'b0);
        add_word(ACT_EXEC, 16'h0000, 8'h00, 1'b0);
        add_word(ACT_EXEC, 16'h0000, 8'h00, 1'b0);
        add_word(ACT_EXEC, 16'h0000, 8'h00, 1'b0);
        // JMP (02FF) with the page wrap on the pointer high byte
        add_word(ACT_WRITE, 16'h0206, 8'h6C, 1'b0);
        add_word(ACT_WRITE, 16'h0207, 8'hFF, 1'b0);
        add_word(ACT_WRITE, 16'h0208, 8'h02, 1'b0);
        add_word(ACT_WRITE, 16'h02FF, 8'h34, 1'b0);
        add_word(ACT_WRITE, 16'h0300, 8'h12, 1'b0);
        add_word(ACT_SETPC, 16'h0206, 8'h00, 1'b0);
        add_word(ACT_EXEC, 16'h0000, 8'h00, 1'b0);
        wait_drained();

        cfg_write(CFG_JMP_BUG, 16'd0);
        cfg_write(CFG_START, 16'hFFFF);
        cfg_write(CFG_STACK, 16'h0000);
        hold_req <= 1'b1;
        gen_random(180, 1'b0);
        wait_drained();

        cfg_write(CFG_JMP_BUG, 16'd1);
        cfg_write(CFG_START, 16'h0000);
        cfg_write(CFG_STACK, 16'h0080);
        add_word(ACT_READ, 16'h01FF, 8'h00, 1'b1);
        gen_random(180, 1'b1);
        wait_drained();

        cfg_write(CFG_JMP_BUG, 16'd0);
        cfg_write(CFG_START, $urandom_range(0, 16'hFFFF));
        cfg_write(CFG_STACK, $urandom_range(0, 255));
        gen_random(180, 1'b0);
        wait_drained();

        $display("Ran %0d words including %0d instructions (%0d undefined opcodes)",
                 n_sent, n_exec, n_bad);
        $display("under four settings of jump bug, start address and stack; %0d errors",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("mos6502_instruction_core test passed");
        end else begin
            $display("mos6502_instruction_core test failed");
        end
        $finish;
    end

endmodule
